[hdl/olad_pkg.sv]
package olad_pkg;

   // Field widths of one beat
   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   // Default store depth
   localparam int DEPTH_DEFAULT = 32;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SHOW   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                append_we;
      logic                shift_we;
      logic                fill_dec;
      logic                fill_clr;
      logic                idx_clr;
      logic                idx_inc;
      logic                load_value;
      logic                rsp_valid;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_item_sel;
      logic                rsp_last;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic full;
      logic idx_end;
      logic idx_last;
      logic match;
   } stat_type;

endpackage

[hdl/olad_ram.sv]
module olad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hdl/olad_dpath.sv]
module olad_dpath #(
   parameter int DEPTH = olad_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  olad_pkg::cmd_type                   cmd,
   output olad_pkg::stat_type                  stat,
   input  logic signed [olad_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_strobe,
   output logic [olad_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [olad_pkg::VALUE_W-1:0] rsp_item,
   output logic                                rsp_last
);
   import olad_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          idx_prev;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      strobe_ff, strobe_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [VALUE_W-1:0] item_ff, item_in;
   logic                      last_ff, last_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] rd_data;

   // Entry store
   olad_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // Select write port: append at tail or move one entry toward head
   assign idx_prev = idx_ff - ONE_CNT;
   assign wr_en    = cmd.append_we | cmd.shift_we;
   assign wr_addr  = cmd.shift_we ? idx_prev[AW-1:0] : fill_ff[AW-1:0];
   assign wr_data  = cmd.shift_we ? rd_data : VALUE_W'(req_value);

   // Report store state to the controller
   always_comb begin
      stat.empty    = (fill_ff == '0);
      stat.full     = (fill_ff == FULL_CNT);
      stat.idx_end  = (idx_ff == fill_ff);
      stat.idx_last = ((idx_ff + ONE_CNT) == fill_ff);
      stat.match    = (rd_data == VALUE_W'(value_ff));
   end

   // Advance fill count, scan index and search value
   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clr) begin
         fill_in = '0;
      end else if (cmd.append_we) begin
         fill_in = fill_ff + ONE_CNT;
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - ONE_CNT;
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ONE_CNT;
      end

      value_in = cmd.load_value ? req_value : value_ff;
   end

   // Build the result beat
   always_comb begin
      strobe_in = cmd.rsp_valid;
      status_in = cmd.rsp_status;
      item_in   = cmd.rsp_item_sel ? $signed(rd_data) : '0;
      last_in   = cmd.rsp_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      item_ff   <= item_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_item   = item_ff;
   assign rsp_last   = last_ff;

endmodule

[hdl/olad_ctrl.sv]
module olad_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [olad_pkg::FUNC_W-1:0]   req_func,
   input  olad_pkg::stat_type            stat,
   output olad_pkg::cmd_type             cmd
);
   import olad_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DL_READ  = 3'd1;
   localparam logic [2:0] S_DL_CHECK = 3'd2;
   localparam logic [2:0] S_MV_READ  = 3'd3;
   localparam logic [2:0] S_MV_WRITE = 3'd4;
   localparam logic [2:0] S_SH_READ  = 3'd5;
   localparam logic [2:0] S_SH_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // Sequence each operation
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_func)
                  FUNC_INSERT: begin
                     cmd.rsp_valid = 1'b1;
                     cmd.rsp_last  = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.append_we  = 1'b1;
                        cmd.rsp_status = ST_INSERTED;
                     end
                  end
                  FUNC_DELETE: begin
                     if (stat.empty) begin
                        cmd.rsp_valid  = 1'b1;
                        cmd.rsp_last   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        cmd.idx_clr    = 1'b1;
                        cmd.load_value = 1'b1;
                        state_in       = S_DL_READ;
                     end
                  end
                  FUNC_SHOW: begin
                     if (stat.empty) begin
                        cmd.rsp_valid  = 1'b1;
                        cmd.rsp_last   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        cmd.idx_clr = 1'b1;
                        state_in    = S_SH_READ;
                     end
                  end
                  FUNC_CLEAR: begin
                     cmd.fill_clr   = 1'b1;
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_last   = 1'b1;
                     cmd.rsp_status = ST_CLEARED;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Wait for the entry under the scan index
         S_DL_READ: begin
            state_in = S_DL_CHECK;
         end
         // Compare; on a hit start closing the gap
         S_DL_CHECK: begin
            if (stat.match) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_MV_READ;
            end else if (stat.idx_last) begin
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_last   = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DL_READ;
            end
         end
         // Read the next entry, or finish when past the tail
         S_MV_READ: begin
            if (stat.idx_end) begin
               cmd.fill_dec   = 1'b1;
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_last   = 1'b1;
               cmd.rsp_status = ST_REMOVED;
               state_in       = S_IDLE;
            end else begin
               state_in = S_MV_WRITE;
            end
         end
         // Move the entry one place toward the head
         S_MV_WRITE: begin
            cmd.shift_we = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_MV_READ;
         end
         S_SH_READ: begin
            state_in = S_SH_EMIT;
         end
         // Emit one listed entry
         S_SH_EMIT: begin
            cmd.rsp_valid    = 1'b1;
            cmd.rsp_status   = ST_LISTED;
            cmd.rsp_item_sel = 1'b1;
            cmd.rsp_last     = stat.idx_last;
            if (stat.idx_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SH_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/ordered_list_append_delete.sv]
// Bounded ordered store of up to DEPTH signed values, head is the oldest entry.
// A request is taken when start is high and busy is low. Insert and clear, and
// delete or show on an empty store, keep busy low and give their single result
// beat on rsp_* in the cycle after the request. Delete reads and checks each
// entry from the head up to the match or the tail, then reads each later entry
// and writes it one place toward the head. Show gives one beat per entry, head
// to tail, with rsp_last on the final one. The entry RAM has registered read
// data and takes one read and one write per cycle. Every result is shown for
// exactly one cycle under rsp_strobe and must be taken then: the receiver
// cannot stall the block.
module ordered_list_append_delete #(
   parameter int DEPTH = olad_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [olad_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [olad_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_strobe,
   output logic [olad_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [olad_pkg::VALUE_W-1:0] rsp_item,
   output logic                                rsp_last
);
   import olad_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   olad_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .req_func(req_func),
      .stat    (stat),
      .cmd     (cmd)
   );

   olad_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_value (req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_item  (rsp_item),
      .rsp_last  (rsp_last)
   );

endmodule

[sim/olad_list_checker.sv]
`timescale 1ns / 100ps

module olad_list_checker #(
   parameter int DEPTH = olad_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [olad_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [olad_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_strobe,
   input  logic [olad_pkg::STATUS_W-1:0]       rsp_status,
   input  logic signed [olad_pkg::VALUE_W-1:0] rsp_item,
   input  logic                                rsp_last,
   output int                                  fail_count,
   output int                                  beats_pending
);

   import olad_pkg::*;

   // One result beat as the block should give it
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] item;
      logic                      last;
   } list_beat_type;

   // Shadow of the store, head at index 0, and the beats still owed
   logic signed [VALUE_W-1:0] stored_values[$];
   list_beat_type             beats_due[$];

   task automatic owe_beat(input logic [STATUS_W-1:0] status,
                           input logic signed [VALUE_W-1:0] item,
                           input logic last);
      list_beat_type b;
      b.status = status;
      b.item   = item;
      b.last   = last;
      beats_due.push_back(b);
   endtask

   // Apply one accepted request to the shadow store and queue its beats
   task automatic apply_list_op(input logic [FUNC_W-1:0] func,
                                input logic signed [VALUE_W-1:0] value);
      int hit;
      int n;
      n = stored_values.size();
      case (func)
         FUNC_INSERT: begin
            if (n >= DEPTH) begin
               owe_beat(ST_FULL, '0, 1'b1);
            end else begin
               stored_values.push_back(value);
               owe_beat(ST_INSERTED, '0, 1'b1);
            end
         end
         FUNC_DELETE: begin
            if (n == 0) begin
               owe_beat(ST_EMPTY, '0, 1'b1);
            end else begin
               // first match counted from the head
               hit = -1;
               for (int i = 0; i < n; i++) begin
                  if (hit < 0 && stored_values[i] == value) hit = i;
               end
               if (hit < 0) begin
                  owe_beat(ST_NOT_FOUND, '0, 1'b1);
               end else begin
                  stored_values.delete(hit);
                  owe_beat(ST_REMOVED, '0, 1'b1);
               end
            end
         end
         FUNC_SHOW: begin
            if (n == 0) begin
               owe_beat(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  owe_beat(ST_LISTED, stored_values[i], (i == n - 1));
               end
            end
         end
         default: begin
            stored_values.delete();
            owe_beat(ST_CLEARED, '0, 1'b1);
         end
      endcase
   endtask

   // Compare one result beat with the oldest owed beat
   task automatic check_beat();
      list_beat_type exp_beat;
      if (beats_due.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected beat status=%0d item=%h last=%b",
                  $time, rsp_status, rsp_item, rsp_last);
      end else begin
         exp_beat = beats_due.pop_front();
         if (rsp_status !== exp_beat.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_beat.status, rsp_status);
         end
         if (rsp_item !== exp_beat.item) begin
            fail_count++;
            $display("%0t: item mismatch, expected %h, actual %h",
                     $time, exp_beat.item, rsp_item);
         end
         if (rsp_last !== exp_beat.last) begin
            fail_count++;
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, exp_beat.last, rsp_last);
         end
      end
   endtask

   initial begin
      fail_count    = 0;
      beats_pending = 0;
   end

   // Predict on request beats first, then check result beats of the same edge
   always @(posedge clock) begin
      if (reset) begin
         stored_values.delete();
         beats_due.delete();
         beats_pending = 0;
      end else begin
         if (start === 1'b1 && busy === 1'b0) apply_list_op(req_func, req_value);
         if (rsp_strobe === 1'b1) begin
            check_beat();
         end else if (rsp_strobe !== 1'b0) begin
            fail_count++;
            $display("%0t: rsp_strobe unknown, expected 0 or 1, actual %b",
                     $time, rsp_strobe);
         end
         beats_pending = beats_due.size();
      end
   end

endmodule

[sim/tb_ordered_list_append_delete.sv]
`timescale 1ns / 100ps

module tb_ordered_list_append_delete;

   import olad_pkg::*;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic [FUNC_W-1:0]         req_func  = FUNC_INSERT;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      busy;
   logic                      rsp_strobe;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_item;
   logic                      rsp_last;
   int                        fail_count;
   int                        beats_pending;

   // Small set of values so that deletes often find a match
   logic [VALUE_W-1:0] value_pool[8];
   bit                 gaps_enabled = 1'b1;

   ordered_list_append_delete i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_item   (rsp_item),
      .rsp_last   (rsp_last)
   );

   olad_list_checker i_list_checker (.*);

   always #1 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #400000;
      $display("** ordered_list_append_delete: FAILED **");
      $finish;
   end

   // Present one request, with an optional gap first, and hold it until taken
   task automatic issue_request(input logic [FUNC_W-1:0] func,
                                input logic [VALUE_W-1:0] value);
      if (gaps_enabled && $urandom_range(0, 99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start and hold off until every owed beat has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (beats_pending != 0);
      @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
      if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return FUNC_INSERT;
      if (r < 72) return FUNC_DELETE;
      if (r < 92) return FUNC_SHOW;
      return FUNC_CLEAR;
   endfunction

   task automatic random_request();
      logic [FUNC_W-1:0] func;
      func = pick_func();
      issue_request(func, pick_value((func == FUNC_DELETE) ? 75 : 60));
   endtask

   initial begin
      foreach (value_pool[k]) value_pool[k] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty store: show, delete and clear
      issue_request(FUNC_SHOW,   32'h0000_0000);
      issue_request(FUNC_DELETE, 32'h0000_0005);
      issue_request(FUNC_CLEAR,  32'h0000_0000);
      // Field extremes and a duplicate
      issue_request(FUNC_INSERT, 32'h8000_0000);
      issue_request(FUNC_INSERT, 32'h7fff_ffff);
      issue_request(FUNC_INSERT, 32'h0000_0000);
      issue_request(FUNC_INSERT, 32'hffff_ffff);
      issue_request(FUNC_INSERT, 32'h7fff_ffff);
      issue_request(FUNC_SHOW,   32'h0000_0000);
      // Miss, first of two matches, head, middle, then drain to empty
      issue_request(FUNC_DELETE, 32'h0000_3039);
      issue_request(FUNC_DELETE, 32'h7fff_ffff);
      issue_request(FUNC_SHOW,   32'h0000_0000);
      issue_request(FUNC_DELETE, 32'h8000_0000);
      issue_request(FUNC_DELETE, 32'hffff_ffff);
      issue_request(FUNC_SHOW,   32'h0000_0000);
      issue_request(FUNC_DELETE, 32'h0000_0000);
      issue_request(FUNC_DELETE, 32'h7fff_ffff);
      issue_request(FUNC_DELETE, 32'h7fff_ffff);
      // Clear a non-empty store
      issue_request(FUNC_INSERT, 32'h5555_5555);
      issue_request(FUNC_INSERT, 32'haaaa_aaaa);
      issue_request(FUNC_CLEAR,  32'h0000_0000);
      issue_request(FUNC_SHOW,   32'h0000_0000);
      wait_drained();

      // Fill past capacity, list the full store, then let it drain
      for (int k = 0; k < 36; k++) issue_request(FUNC_INSERT, pick_value(60));
      issue_request(FUNC_SHOW, 32'h0000_0000);
      wait_drained();

      // Mixed traffic with gaps, then back to back
      for (int k = 0; k < 80; k++) random_request();
      gaps_enabled = 1'b0;
      for (int k = 0; k < 30; k++) random_request();

      wait_drained();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && beats_pending == 0) begin
         $display("** ordered_list_append_delete: PASSED **");
      end else begin
         $display("** ordered_list_append_delete: FAILED **");
      end
      $finish;
   end

endmodule
